// ----- hw/rtl/gn_pkg.sv -----
// Package: shared types, constants, permutation ROM and mode mapping for gradient noise.
package gn_pkg;

   // Dimension codes of the mode register
   localparam logic [2:0] DIM_2D = 3'd2;
   localparam logic [2:0] DIM_3D = 3'd3;
   localparam logic [2:0] DIM_4D = 3'd4;

   // Register index of the mode register
   localparam logic [0:0] REG_DIMENSIONS = 1'b0;

   localparam int OUT_W = 19;
   localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sh3FFFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sh40000;

   typedef enum logic [2:0] {
      MODE_2D = 3'b001,
      MODE_3D = 3'b010,
      MODE_4D = 3'b100
   } mode_type;

   // Permutation ROM, 256 entries, index wraps modulo 256
   function automatic logic [7:0] perm(input logic [7:0] idx);
      logic [7:0] r;
      unique case (idx)
         8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
         8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
         8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
         8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
         8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
         8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
         8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
         8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
         8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
         8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
         8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
         8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
         8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
         8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
         8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
         8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
         8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
         8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
         8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
         8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
         8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
         8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
         8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
         8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
         8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
         8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
         8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
         8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
         8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
         8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
         8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
         8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
         8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
         8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
         8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
         8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
         8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
         8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
         8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
         8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
         8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
         8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
         8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
         8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
         8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
         8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
         8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
         8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
         8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
         8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
         8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
         8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
         8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
         8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
         8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
         8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
         8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
         8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
         8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
         8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
         8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
         8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
         8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
         8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   // Map a register value to a mode; unused codes select 3D
   function automatic mode_type dim_to_mode(input logic [2:0] d);
      mode_type m;
      if (d == DIM_2D) m = MODE_2D;
      else if (d == DIM_4D) m = MODE_4D;
      else m = MODE_3D;
      return m;
   endfunction

endpackage

// ----- hw/rtl/gn_if.sv -----
// Interfaces: valid/ready channels for points and noise results.
interface gn_point_if #(parameter int W = 32);
   logic valid;
   logic ready;
   logic signed [W-1:0] x_coord;
   logic signed [W-1:0] y_coord;
   logic signed [W-1:0] z_coord;
   logic signed [W-1:0] w_coord;
   modport source (output valid, x_coord, y_coord, z_coord, w_coord, input ready);
   modport sink (input valid, x_coord, y_coord, z_coord, w_coord, output ready);
endinterface

interface gn_noise_if;
   logic valid;
   logic ready;
   logic signed [18:0] noise_value;
   modport source (output valid, noise_value, input ready);
   modport sink (input valid, noise_value, output ready);
endinterface

// ----- hw/rtl/gn_hash.sv -----
// Hash stage chain: cell indices to the 16 corner gradient hashes, over four stages.
module gn_hash (
   input  logic        clock,
   input  logic        en,
   input  logic [7:0]  cx,
   input  logic [7:0]  cy,
   input  logic [7:0]  cz,
   input  logic [7:0]  cw,
   output logic [7:0]  hash [16]
);
   // stage 1: a, b
   logic [7:0] a_ff, b_ff, a_in, b_in;
   logic [7:0] cz1_ff, cw1_ff, cz2_ff, cw2_ff, cw3_ff;
   // stage 2: aa, ab, ba, bb (before adding z)
   logic [7:0] p2_ff [4];
   logic [7:0] p2_in [4];
   // stage 3: h for the 8 xyz corners
   logic [7:0] p3_ff [8];
   logic [7:0] p3_in [8];
   logic [7:0] p4_in [16];
   logic [7:0] p4_ff [16];

   always_comb begin
      a_in = gn_pkg::perm(cx) + cy;
      b_in = gn_pkg::perm(cx + 8'd1) + cy;
      p2_in[0] = gn_pkg::perm(a_ff);
      p2_in[1] = gn_pkg::perm(a_ff + 8'd1);
      p2_in[2] = gn_pkg::perm(b_ff);
      p2_in[3] = gn_pkg::perm(b_ff + 8'd1);
      // index = {x,y,z}: entry j of p2 is {x=j[1], y=j[0]}
      for (int j = 0; j < 4; j++) begin
         p3_in[2*j]   = gn_pkg::perm(p2_ff[j] + cz2_ff);
         p3_in[2*j+1] = gn_pkg::perm(p2_ff[j] + cz2_ff + 8'd1);
      end
      // 4D corners: {x,y,z,w}; entry k of p3 is {x,y,z}
      for (int k = 0; k < 8; k++) begin
         p4_in[2*k]   = gn_pkg::perm(p3_ff[k] + cw3_ff);
         p4_in[2*k+1] = gn_pkg::perm(p3_ff[k] + cw3_ff + 8'd1);
      end
   end

   // Advance the hash chain
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
         cz1_ff <= cz;
         cw1_ff <= cw;
         cz2_ff <= cz1_ff;
         cw2_ff <= cw1_ff;
         cw3_ff <= cw2_ff;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         p4_ff <= p4_in;
      end
   end

   // Present the 4D corner hashes, index {x,y,z,w}
   always_comb begin
      for (int i = 0; i < 16; i++) hash[i] = p4_ff[i];
   end
endmodule

// ----- hw/rtl/gn_ease.sv -----
// Ease stage chain: fraction t to 6t^5-15t^4+10t^3, one multiply per stage.
module gn_ease #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [FRAC_BITS-1:0] t,
   output logic [FRAC_BITS:0]   e
);
   localparam int SW = FRAC_BITS + 6;
   localparam int PW = 2 * SW;
   localparam logic signed [SW-1:0] ONE = SW'(1) <<< FRAC_BITS;

   logic [FRAC_BITS-1:0] t_ff [4];
   logic signed [SW-1:0] s_ff [4];
   logic signed [SW-1:0] s_in [4];
   logic [FRAC_BITS:0] e_ff;
   logic [FRAC_BITS:0] e_in;

   function automatic logic signed [SW-1:0] mulq(input logic [FRAC_BITS-1:0] a,
                                                 input logic signed [SW-1:0] b);
      logic signed [PW-1:0] p;
      logic [PW-1:0] m;
      p = $signed({{(PW-FRAC_BITS){1'b0}}, a}) * PW'(b);
      m = p[PW-1] ? PW'(-p) : PW'(p);
      m = (m + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return p[PW-1] ? -SW'(m) : SW'(m);
   endfunction

   always_comb begin
      s_in[0] = SW'(6 * $signed({{(SW-FRAC_BITS){1'b0}}, t}) - 15 * ONE);
      s_in[1] = SW'(mulq(t_ff[0], s_ff[0]) + 10 * ONE);
      s_in[2] = mulq(t_ff[1], s_ff[1]);
      s_in[3] = mulq(t_ff[2], s_ff[2]);
      begin
         logic signed [SW-1:0] f;
         f = mulq(t_ff[3], s_ff[3]);
         if (f < 0) e_in = '0;
         else if (f > ONE) e_in = (FRAC_BITS+1)'(ONE);
         else e_in = f[FRAC_BITS:0];
      end
   end

   // Advance the ease chain
   always_ff @(posedge clock) begin
      if (en) begin
         t_ff[0] <= t;
         for (int i = 1; i < 4; i++) t_ff[i] <= t_ff[i-1];
         s_ff <= s_in;
         e_ff <= e_in;
      end
   end

   assign e = e_ff;
endmodule

// ----- hw/rtl/gn_blend.sv -----
// Blend stages: gradient dots, then x, y, z and w lerps, one per stage.
module gn_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  gn_pkg::mode_type            mode,
   input  logic [7:0]                  hash [16],
   input  logic [FRAC_BITS-1:0]        f0 [4],
   input  logic [FRAC_BITS:0]          e [4],
   output logic signed [FRAC_BITS+4:0] r
);
   // value width: up to 4*one plus growth in lerps
   localparam int VW = FRAC_BITS + 5;
   localparam int PW = VW + FRAC_BITS + 3;
   localparam logic signed [VW-1:0] ONE = VW'(1) <<< FRAC_BITS;

   function automatic logic signed [VW-1:0] lerp(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b,
                                                 input logic [FRAC_BITS:0] t);
      logic signed [PW-1:0] p;
      logic [PW-1:0] m;
      logic signed [VW-1:0] q;
      p = $signed({{(PW-FRAC_BITS-1){1'b0}}, t}) * (PW'(b) - PW'(a));
      m = p[PW-1] ? PW'(-p) : PW'(p);
      m = (m + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      q = p[PW-1] ? -VW'(m) : VW'(m);
      return a + q;
   endfunction

   function automatic logic signed [VW-1:0] sel(input logic neg,
                                                input logic signed [VW-1:0] v);
      return neg ? -v : v;
   endfunction

   // Corner offsets
   logic signed [VW-1:0] o [4][2];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         o[i][0] = $signed({{(VW-FRAC_BITS){1'b0}}, f0[i]});
         o[i][1] = o[i][0] - ONE;
      end
   end

   // Gradient dots for the 16 corners; index = {x,y,z,w}
   logic signed [VW-1:0] n_in [16];
   logic signed [VW-1:0] n_ff [16];
   gn_pkg::mode_type mode1_ff, mode2_ff, mode3_ff, mode4_ff;
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         logic signed [VW-1:0] x, y, z, w, u, v;
         logic [7:0] h;
         logic [4:0] g;
         x = o[0][k[3]];
         y = o[1][k[2]];
         z = o[2][k[1]];
         w = o[3][k[0]];
         h = hash[k];
         g = h[4:0];
         u = '0;
         v = '0;
         n_in[k] = '0;
         unique case (mode)
            gn_pkg::MODE_2D: begin
               u = h[2] ? y : x;
               v = h[2] ? x : y;
               n_in[k] = sel(h[0], u) + sel(h[1], v);
            end
            gn_pkg::MODE_3D: begin
               u = h[3] ? y : x;
               v = (h[3:2] == 2'b00) ? y :
                   ((h[3:0] == 4'd12 || h[3:0] == 4'd14) ? x : z);
               n_in[k] = sel(h[0], u) + sel(h[1], v);
            end
            gn_pkg::MODE_4D: begin
               unique case (g[4:3])
                  2'd0: n_in[k] = sel(g[2], y) + sel(g[1], z) + sel(g[0], w);
                  2'd1: n_in[k] = sel(g[2], x) + sel(g[1], z) + sel(g[0], w);
                  2'd2: n_in[k] = sel(g[2], x) + sel(g[1], y) + sel(g[0], w);
                  default: n_in[k] = sel(g[2], x) + sel(g[1], y) + sel(g[0], z);
               endcase
            end
            default: n_in[k] = '0;
         endcase
      end
   end

   // x lerps: 8 values indexed {y,z,w}
   logic signed [VW-1:0] lx_ff [8];
   logic signed [VW-1:0] ly_ff [4];
   logic signed [VW-1:0] lz_ff [2];
   logic signed [VW-1:0] lw_ff;
   logic [FRAC_BITS:0] e1_ff [4];
   logic [FRAC_BITS:0] e2_ff [4];
   logic [FRAC_BITS:0] e3_ff [4];

   // Advance the lerp stages; eased weights arrive together with the dots
   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= n_in;
         mode1_ff <= mode;
         for (int j = 0; j < 8; j++) lx_ff[j] <= lerp(n_ff[j], n_ff[j+8], e[0]);
         e1_ff <= e;
         mode2_ff <= mode1_ff;
         for (int j = 0; j < 4; j++) ly_ff[j] <= lerp(lx_ff[j], lx_ff[j+4], e1_ff[1]);
         e2_ff <= e1_ff;
         mode3_ff <= mode2_ff;
         // z stage: 2D passes its y result through
         if (mode3_ff == gn_pkg::MODE_2D) lz_ff[0] <= ly_ff[0];
         else lz_ff[0] <= lerp(ly_ff[0], ly_ff[2], e2_ff[2]);
         lz_ff[1] <= lerp(ly_ff[1], ly_ff[3], e2_ff[2]);
         e3_ff <= e2_ff;
         mode4_ff <= mode3_ff;
         // final stage: only 4D blends along w
         if (mode4_ff == gn_pkg::MODE_4D) lw_ff <= lerp(lz_ff[0], lz_ff[1], e3_ff[3]);
         else lw_ff <= lz_ff[0];
      end
   end

   assign r = lw_ff;
endmodule

// ----- hw/rtl/gradient_noise_2d_3d_4d_top.sv -----
// Top level: gradient noise point pipeline with APB mode register.
// Gradient noise, 2D/3D/4D. One point is taken per cycle while the result
// side is not stalled; the pipeline depth is set by the four-stage permutation
// hash chain, the dot stage, the four lerp stages and the output register.
// A stall on the result side freezes the whole pipeline, so nothing is lost.
// The mode register (address 0) should be written only while the pipeline
// is empty.
module gradient_noise_2d_3d_4d_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   gn_point_if.sink    req,
   gn_noise_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int DEPTH = 9;
   localparam int VW = FRAC_BITS + 5;

   logic [2:0] dim_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {29'd0, dim_ff};

   // Hold the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= gn_pkg::DIM_3D;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[1:1] == gn_pkg::REG_DIMENSIONS) begin
         dim_ff <= csr_pwdata[2:0];
      end
   end

   gn_pkg::mode_type mode;
   assign mode = gn_pkg::dim_to_mode(dim_ff);

   // Output register with pipeline stall
   logic en;
   logic [DEPTH-1:0] v_ff;
   logic out_v_ff;
   logic signed [18:0] out_ff;
   assign en = !out_v_ff || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= {v_ff[DEPTH-2:0], req.valid};
         out_v_ff <= v_ff[DEPTH-1];
      end
   end

   // Cell indices and fractions
   logic [7:0] c [4];
   logic [FRAC_BITS-1:0] f [4];
   logic [31:0] raw [4];
   always_comb begin
      raw[0] = req.x_coord; raw[1] = req.y_coord;
      raw[2] = req.z_coord; raw[3] = req.w_coord;
      for (int i = 0; i < 4; i++) begin
         c[i] = raw[i][FRAC_BITS +: 8];
         f[i] = raw[i][FRAC_BITS-1:0];
      end
   end

   // 4D corner hashes from the full chain
   logic [7:0] hash [16];
   logic [7:0] hsel [16];
   gn_hash u_hash (.clock, .en, .cx(c[0]), .cy(c[1]), .cz(c[2]), .cw(c[3]),
                   .hash(hash));

   // 2D corner hashes: pm(pm(pm(cx)+cy)) etc., delayed to line up with hash chain
   logic [7:0] a2_ff, b2_ff;
   logic [7:0] q2_ff [4];
   logic [7:0] q3_ff [4];
   logic [7:0] q4_ff [4];
   always_ff @(posedge clock) begin
      if (en) begin
         a2_ff <= gn_pkg::perm(c[0]) + c[1];
         b2_ff <= gn_pkg::perm(c[0] + 8'd1) + c[1];
         q2_ff[0] <= gn_pkg::perm(a2_ff);
         q2_ff[1] <= gn_pkg::perm(a2_ff + 8'd1);
         q2_ff[2] <= gn_pkg::perm(b2_ff);
         q2_ff[3] <= gn_pkg::perm(b2_ff + 8'd1);
         for (int j = 0; j < 4; j++) q3_ff[j] <= gn_pkg::perm(q2_ff[j]);
         q4_ff <= q3_ff;
      end
   end

   // 3D corner hashes pm(aa+dz) aligned with the hash chain output
   logic [7:0] h3d_ff [8];
   logic [7:0] a3_ff, b3_ff, cz3a_ff, cz3b_ff;
   logic [7:0] r3_ff [4];
   logic [7:0] s3_ff [8];
   always_ff @(posedge clock) begin
      if (en) begin
         a3_ff <= gn_pkg::perm(c[0]) + c[1];
         b3_ff <= gn_pkg::perm(c[0] + 8'd1) + c[1];
         cz3a_ff <= c[2];
         cz3b_ff <= cz3a_ff;
         r3_ff[0] <= gn_pkg::perm(a3_ff);
         r3_ff[1] <= gn_pkg::perm(a3_ff + 8'd1);
         r3_ff[2] <= gn_pkg::perm(b3_ff);
         r3_ff[3] <= gn_pkg::perm(b3_ff + 8'd1);
         for (int j = 0; j < 4; j++) begin
            s3_ff[2*j]   <= gn_pkg::perm(r3_ff[j] + cz3b_ff);
            s3_ff[2*j+1] <= gn_pkg::perm(r3_ff[j] + cz3b_ff + 8'd1);
         end
         h3d_ff <= s3_ff;
      end
   end

   // Arrange into {x,y,z,w} index order; 3D ignores w, 2D ignores z and w
   always_comb begin
      for (int k = 0; k < 16; k++) hsel[k] = hash[k];
      unique case (mode)
         gn_pkg::MODE_2D: begin
            for (int k = 0; k < 16; k++) hsel[k] = q4_ff[k >> 2];
         end
         gn_pkg::MODE_3D: begin
            for (int k = 0; k < 16; k++) hsel[k] = h3d_ff[k >> 1];
         end
         default: begin
            for (int k = 0; k < 16; k++) hsel[k] = hash[k];
         end
      endcase
   end

   // Delay fractions to the dot stage and run ease in parallel
   logic [FRAC_BITS-1:0] fd_ff [4][4];
   logic [FRAC_BITS:0] e [4];
   always_ff @(posedge clock) begin
      if (en) begin
         fd_ff[0] <= f;
         for (int i = 1; i < 4; i++) fd_ff[i] <= fd_ff[i-1];
      end
   end

   genvar g;
   generate
      for (g = 0; g < 4; g++) begin : g_ease
         gn_ease #(.FRAC_BITS(FRAC_BITS)) u_ease (.clock, .en, .t(f[g]), .e(e[g]));
      end
   endgenerate

   // Ease output lines up with the dots; the x lerps take it
   logic signed [VW-1:0] r;
   gn_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock, .en, .mode, .hash(hsel), .f0(fd_ff[3]), .e(e), .r(r));

   // Rescale to 16 fraction bits and saturate
   logic signed [VW+16:0] rs;
   logic signed [18:0] sat;
   always_comb begin
      if (FRAC_BITS > 16) begin
         logic [VW+16:0] m;
         m = r[VW-1] ? (VW+17)'(-r) : (VW+17)'(r);
         m = (m + ((VW+17)'(1) << (FRAC_BITS - 17))) >> (FRAC_BITS - 16);
         rs = r[VW-1] ? -$signed(m) : $signed(m);
      end else begin
         rs = (VW+17)'(r) <<< (16 - FRAC_BITS);
      end
      if (rs > (VW+17)'(gn_pkg::OUT_MAX)) sat = gn_pkg::OUT_MAX;
      else if (rs < (VW+17)'(gn_pkg::OUT_MIN)) sat = gn_pkg::OUT_MIN;
      else sat = rs[18:0];
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= sat;
   end

   assign rsp.valid = out_v_ff;
   assign rsp.noise_value = out_ff;
endmodule

// ----- dv/tb_top.sv -----
// Testbench top: drives points, predicts gradient noise and checks every result.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = 16;
   localparam int LATENCY = 10;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] w;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   gn_point_if req ();
   gn_noise_if rsp ();

   gradient_noise_2d_3d_4d_top dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   point_type pending_points[$];
   logic signed [18:0] expected_noise[$];
   logic [2:0] dim_reg = gn_pkg::DIM_3D;
   int errors = 0;
   int cycles = 0;
   int checked = 0;
   int mode_count[3];
   bit calm = 1'b0;
   int src_gap = 0, snk_gap = 0;

   // Permutation lookup with modulo-256 wrap
   function automatic int unsigned pmt(input int unsigned i);
      return int'(gn_pkg::perm(i[7:0]));
   endfunction

   function automatic longint rnd_shift(input longint v);
      longint half;
      half = 64'sd1 <<< (FB - 1);
      if (v >= 0) return (v + half) >>> FB;
      return -((-v + half) >>> FB);
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return rnd_shift(a * b);
   endfunction

   function automatic longint fade(input longint t);
      longint one, s;
      one = 64'sd1 <<< FB;
      s = 6 * t - 15 * one;
      s = qmul(t, s) + 10 * one;
      s = qmul(t, s);
      s = qmul(t, s);
      s = qmul(t, s);
      if (s < 0) s = 0;
      if (s > one) s = one;
      return s;
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint t);
      return a + qmul(t, b - a);
   endfunction

   function automatic longint g2(input int unsigned hash, input longint x, input longint y);
      int unsigned h;
      longint u, v;
      h = hash & 7;
      u = (h < 4) ? x : y;
      v = (h < 4) ? y : x;
      return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
   endfunction

   function automatic longint g3(input int unsigned hash, input longint x, input longint y,
                                 input longint z);
      int unsigned h;
      longint u, v;
      h = hash & 15;
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
   endfunction

   // 32 gradients: one axis zeroed in groups of eight, signs from the low bits
   function automatic longint g4(input int unsigned hash, input longint x, input longint y,
                                 input longint z, input longint w);
      int unsigned h, zero_axis;
      longint v[4], a[3], s;
      int k;
      h = hash & 31;
      zero_axis = h >> 3;
      v[0] = x; v[1] = y; v[2] = z; v[3] = w;
      k = 0;
      for (int i = 0; i < 4; i++)
         if (i != zero_axis) begin
            a[k] = v[i];
            k++;
         end
      s = ((h & 4) ? -a[0] : a[0]) + ((h & 2) ? -a[1] : a[1]) + ((h & 1) ? -a[2] : a[2]);
      return s;
   endfunction

   function automatic logic signed [18:0] noise_at(input point_type p, input logic [2:0] d);
      longint one, f0[4], f1[4], e[4], r, lo, hi, n[16], zw[4], wv[2];
      int unsigned c[4], a, b, aa, ab, ba, bb, hh[8];
      logic [31:0] raw[4];
      gn_pkg::mode_type m;
      one = 64'sd1 <<< FB;
      raw[0] = p.x; raw[1] = p.y; raw[2] = p.z; raw[3] = p.w;
      for (int i = 0; i < 4; i++) begin
         c[i] = raw[i][FB+7:FB];
         f0[i] = raw[i][FB-1:0];
         f1[i] = f0[i] - one;
         e[i] = fade(f0[i]);
      end
      m = gn_pkg::dim_to_mode(d);
      a = pmt(c[0]) + c[1];
      b = pmt(c[0] + 1) + c[1];
      if (m == gn_pkg::MODE_2D) begin
         aa = pmt(a); ab = pmt(a + 1); ba = pmt(b); bb = pmt(b + 1);
         r = blend(blend(g2(pmt(aa), f0[0], f0[1]), g2(pmt(ba), f1[0], f0[1]), e[0]),
                   blend(g2(pmt(ab), f0[0], f1[1]), g2(pmt(bb), f1[0], f1[1]), e[0]), e[1]);
      end else begin
         aa = pmt(a) + c[2]; ab = pmt(a + 1) + c[2];
         ba = pmt(b) + c[2]; bb = pmt(b + 1) + c[2];
         if (m == gn_pkg::MODE_4D) begin
            // hh index: x*4 + y*2 + z
            hh[0] = pmt(aa) + c[3]; hh[1] = pmt(aa + 1) + c[3];
            hh[2] = pmt(ab) + c[3]; hh[3] = pmt(ab + 1) + c[3];
            hh[4] = pmt(ba) + c[3]; hh[5] = pmt(ba + 1) + c[3];
            hh[6] = pmt(bb) + c[3]; hh[7] = pmt(bb + 1) + c[3];
            for (int k = 0; k < 16; k++)
               n[k] = g4(pmt(hh[k >> 1] + (k & 1)),
                         (k & 8) ? f1[0] : f0[0], (k & 4) ? f1[1] : f0[1],
                         (k & 2) ? f1[2] : f0[2], (k & 1) ? f1[3] : f0[3]);
            for (int zw_i = 0; zw_i < 4; zw_i++)
               zw[zw_i] = blend(blend(n[zw_i], n[8 + zw_i], e[0]),
                                blend(n[4 + zw_i], n[12 + zw_i], e[0]), e[1]);
            wv[0] = blend(zw[0], zw[2], e[2]);
            wv[1] = blend(zw[1], zw[3], e[2]);
            r = blend(wv[0], wv[1], e[3]);
         end else begin
            lo = blend(blend(g3(pmt(aa), f0[0], f0[1], f0[2]),
                             g3(pmt(ba), f1[0], f0[1], f0[2]), e[0]),
                       blend(g3(pmt(ab), f0[0], f1[1], f0[2]),
                             g3(pmt(bb), f1[0], f1[1], f0[2]), e[0]), e[1]);
            hi = blend(blend(g3(pmt(aa + 1), f0[0], f0[1], f1[2]),
                             g3(pmt(ba + 1), f1[0], f0[1], f1[2]), e[0]),
                       blend(g3(pmt(ab + 1), f0[0], f1[1], f1[2]),
                             g3(pmt(bb + 1), f1[0], f1[1], f1[2]), e[0]), e[1]);
            r = blend(lo, hi, e[2]);
         end
      end
      if (r > 262143) r = 262143;
      if (r < -262144) r = -262144;
      return r[18:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0d: %s", cycles, what);
      errors++;
   endtask

   // Cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Driver: present the oldest pending item, idle in random bursts
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         // the accepted item leaves the queue, so the next one sits at the front
         if (req.valid && req.ready) begin
            expected_noise.push_back(noise_at(pending_points.pop_front(), dim_reg));
            mode_count[gn_pkg::dim_to_mode(dim_reg) == gn_pkg::MODE_2D ? 0 :
                       gn_pkg::dim_to_mode(dim_reg) == gn_pkg::MODE_4D ? 2 : 1]++;
         end
         if (src_gap > 0) begin
            src_gap <= src_gap - 1;
            req.valid <= 1'b0;
         end else if (!(req.valid && !req.ready) && !calm && $urandom_range(0, 9) == 0) begin
            src_gap <= $urandom_range(0, 11);
            req.valid <= 1'b0;
         end else if (pending_points.size() > 0) begin
            req.valid <= 1'b1;
            req.x_coord <= pending_points[0].x;
            req.y_coord <= pending_points[0].y;
            req.z_coord <= pending_points[0].z;
            req.w_coord <= pending_points[0].w;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Monitor: check each accepted result, stall the sink in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_noise.size() == 0)
               report_mismatch("result with no item outstanding");
            else begin
               if (rsp.noise_value !== expected_noise[0])
                  report_mismatch($sformatf("noise_value got %0d expected %0d",
                                            rsp.noise_value, expected_noise[0]));
               void'(expected_noise.pop_front());
               checked++;
            end
         end
         if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            rsp.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            snk_gap <= $urandom_range(0, 11);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input logic [2:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {gn_pkg::REG_DIMENSIONS, 1'b0}; csr_pwdata <= {29'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      dim_reg = value;
   endtask

   task automatic drain();
      while (pending_points.size() != 0 || req.valid || expected_noise.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      unique case ($urandom_range(0, 5))
         0: return $urandom;
         1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         2: return {16'($urandom), 16'h0000};
         3: return {16'($urandom), 16'hFFFF};
         default: return {{8{1'b0}} ^ {8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      endcase
   endfunction

   task automatic queue_random(input int count);
      point_type p;
      repeat (count) begin
         p.x = rand_coord(); p.y = rand_coord(); p.z = rand_coord(); p.w = rand_coord();
         pending_points.push_back(p);
      end
   endtask

   initial begin
      logic [2:0] modes[9];
      point_type p;
      req.valid = 1'b0; rsp.ready = 1'b0;
      req.x_coord = '0; req.y_coord = '0; req.z_coord = '0; req.w_coord = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset mode first, then field extremes in each mode
      for (int d = 0; d < 4; d++) begin
         if (d == 1) csr_write(gn_pkg::DIM_2D);
         if (d == 2) csr_write(gn_pkg::DIM_4D);
         if (d == 3) csr_write(3'd7);
         p = '{32'sh0, 32'sh0, 32'sh0, 32'sh0}; pending_points.push_back(p);
         p = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
         pending_points.push_back(p);
         p = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
         pending_points.push_back(p);
         p = '{32'sh00008000, 32'shFFFF8000, 32'sh0000FFFF, 32'sh00FF0001};
         pending_points.push_back(p);
         p = '{32'shFFFFFFFF, 32'sh00000001, 32'sh7FFF8000, 32'sh80007FFF};
         pending_points.push_back(p);
         drain();
      end

      // Random phases across register codes 0 to 6, extremes included
      modes = '{3'd0, gn_pkg::DIM_2D, gn_pkg::DIM_3D, gn_pkg::DIM_4D, 3'd1, 3'd5,
                gn_pkg::DIM_4D, 3'd6, gn_pkg::DIM_2D};
      foreach (modes[i]) begin
         csr_write(modes[i]);
         if (i == 8) calm = 1'b1;
         queue_random(i < 8 ? 100 : 130);
         drain();
      end

      $display("checked %0d results: %0d in 2D, %0d in 3D, %0d in 4D mode",
               checked, mode_count[0], mode_count[1], mode_count[2]);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
